@@ src/rtpfu_pkg.sv @@
// ----------------------------------------------------------------------------
// rtpfu_pkg
// Shared types and constants of the RTP H.264 FU-A packetizer: register
// indexes, reset values, header constants and the front-to-back command.
// ----------------------------------------------------------------------------
package rtpfu_pkg;

    // longest unit taken by default
    localparam int unsigned MAX_UNIT_BYTES_DEF = 65535;

    // command queue between front and back
    localparam int CMD_DEPTH = 4;

    // configuration register indexes
    localparam logic [1:0] REG_PAYLOAD_TYPE = 2'd0;
    localparam logic [1:0] REG_SSRC         = 2'd1;
    localparam logic [1:0] REG_TS_STEP      = 2'd2;
    localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd3;

    // register reset values
    localparam logic [6:0]  PT_RESET          = 7'd96;
    localparam logic [31:0] SSRC_RESET        = 32'd10;
    localparam logic [31:0] TS_STEP_RESET     = 32'd3600;
    localparam logic [10:0] MAX_PAYLOAD_RESET = 11'd1400;

    // payload limit is used clamped to this range
    localparam logic [10:0] PAYLOAD_MIN = 11'd16;
    localparam logic [10:0] PAYLOAD_MAX = 11'd1460;

    // header constants
    localparam logic [7:0] RTP_V2_BYTE  = 8'h80;
    localparam logic [4:0] FU_A_TYPE    = 5'd28;

    // byte position within a run
    localparam int         IDX_W        = 4;
    localparam logic [3:0] LAST_SINGLE  = 4'd12;
    localparam logic [3:0] LAST_FRAG    = 4'd14;
    localparam logic [3:0] IDX_FU_IND   = 4'd12;
    localparam logic [3:0] IDX_FU_HDR   = 4'd13;

    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_SINGLE,
        CMD_FRAG
    } cmd_kind_t;

    // one classified request, expanded by the back end into 1, 13 or 15 bytes
    typedef struct packed {
        cmd_kind_t   kind;
        logic        marker;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [7:0]  data;
        logic        pend;
    } cmd_t;

    // header fields that come straight from configuration
    typedef struct packed {
        logic [6:0]  payload_type;
        logic [31:0] ssrc;
    } hdr_cfg_t;

endpackage

@@ src/rtpfu_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// rtpfu_cmd_fifo
// Small flop-based queue of commands between the front and the back end.
// ----------------------------------------------------------------------------
module rtpfu_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  rtpfu_pkg::cmd_t wr_cmd,
    input  logic          rd_en,
    output rtpfu_pkg::cmd_t rd_cmd,
    output logic          full,
    output logic          valid
);
    import rtpfu_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             mem_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    // status
    assign full   = (count_reg == CNT_W'(CMD_DEPTH));
    assign valid  = (count_reg != '0);
    assign rd_cmd = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

@@ src/rtpfu_front.sv @@
// ----------------------------------------------------------------------------
// rtpfu_front
// Takes NAL bytes, tracks unit and fragment state, holds the configuration
// registers and turns each byte into at most one command for the back end.
// ----------------------------------------------------------------------------
module rtpfu_front #(
    parameter int unsigned MAX_UNIT_BYTES = rtpfu_pkg::MAX_UNIT_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         nal_byte,
    input  logic               starts_unit,
    input  logic [15:0]        unit_length,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output rtpfu_pkg::hdr_cfg_t hdr_cfg,
    output logic               cmd_push,
    output rtpfu_pkg::cmd_t    cmd
);
    import rtpfu_pkg::*;

    logic [6:0]  pt_reg;
    logic [31:0] ssrc_reg;
    logic [31:0] ts_step_reg;
    logic [10:0] max_payload_reg;

    logic [15:0] seq_reg,   seq_next;
    logic [31:0] ts_reg,    ts_next;
    logic [15:0] left_reg,  left_next;
    logic [10:0] fill_reg,  fill_next;
    logic [7:0]  hdr_reg,   hdr_next;
    logic        frag_reg,  frag_next;
    logic        first_reg, first_next;

    logic [10:0] mp;
    logic [15:0] len_raw;
    logic [15:0] len;
    logic [31:0] ts_sum;
    logic [15:0] left_dec;
    logic [10:0] fill_inc;
    logic        last_frag;

    assign hdr_cfg.payload_type = pt_reg;
    assign hdr_cfg.ssrc         = ssrc_reg;

    // clamp the payload limit and the unit length
    always_comb
    begin
        if (max_payload_reg < PAYLOAD_MIN)
        begin
            mp = PAYLOAD_MIN;
        end
        else if (max_payload_reg > PAYLOAD_MAX)
        begin
            mp = PAYLOAD_MAX;
        end
        else
        begin
            mp = max_payload_reg;
        end
        len_raw = (unit_length == 16'd0) ? 16'd1 : unit_length;
        len     = ({16'd0, len_raw} > 32'(MAX_UNIT_BYTES)) ? 16'(MAX_UNIT_BYTES) : len_raw;
    end

    assign ts_sum    = ts_reg + ts_step_reg;
    assign left_dec  = left_reg - 16'd1;
    assign fill_inc  = fill_reg + 11'd1;
    assign last_frag = (left_reg <= {5'd0, mp});

    // classify the byte and work out the next unit state
    always_comb
    begin
        seq_next   = seq_reg;
        ts_next    = ts_reg;
        left_next  = left_reg;
        fill_next  = fill_reg;
        hdr_next   = hdr_reg;
        frag_next  = frag_reg;
        first_next = first_reg;
        cmd_push   = 1'b0;
        cmd.kind   = CMD_DATA;
        cmd.marker = 1'b0;
        cmd.seq    = seq_reg;
        cmd.ts     = ts_reg;
        cmd.fu_ind = {hdr_reg[7:5], FU_A_TYPE};
        cmd.fu_hdr = {first_reg, last_frag, 1'b0, hdr_reg[4:0]};
        cmd.data   = nal_byte;
        cmd.pend   = 1'b0;
        if (accept)
        begin
            if (starts_unit)
            begin
                ts_next   = ts_sum;
                hdr_next  = nal_byte;
                fill_next = 11'd0;
                left_next = len - 16'd1;
                if (len <= {5'd0, mp})
                begin
                    // unit fits in one packet
                    frag_next  = 1'b0;
                    first_next = 1'b0;
                    cmd_push   = 1'b1;
                    cmd.kind   = CMD_SINGLE;
                    cmd.marker = 1'b1;
                    cmd.ts     = ts_sum;
                    cmd.pend   = (len == 16'd1);
                    seq_next   = seq_reg + 16'd1;
                end
                else
                begin
                    // header byte kept for the FU-A fields
                    frag_next  = 1'b1;
                    first_next = 1'b1;
                end
            end
            else if (left_reg != 16'd0)
            begin
                left_next = left_dec;
                cmd_push  = 1'b1;
                if (frag_reg)
                begin
                    cmd.pend = (left_dec == 16'd0) || (fill_inc >= mp);
                    if (fill_reg == 11'd0)
                    begin
                        // fragment opens with its own headers
                        cmd.kind   = CMD_FRAG;
                        cmd.marker = last_frag;
                        seq_next   = seq_reg + 16'd1;
                        first_next = 1'b0;
                    end
                    fill_next = cmd.pend ? 11'd0 : fill_inc;
                    if (left_dec == 16'd0)
                    begin
                        frag_next = 1'b0;
                    end
                end
                else
                begin
                    cmd.pend = (left_dec == 16'd0);
                end
            end
        end
    end

    // unit state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_reg          <= PT_RESET;
            ssrc_reg        <= SSRC_RESET;
            ts_step_reg     <= TS_STEP_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
            seq_reg         <= '0;
            ts_reg          <= '0;
            left_reg        <= '0;
            fill_reg        <= '0;
            hdr_reg         <= '0;
            frag_reg        <= 1'b0;
            first_reg       <= 1'b0;
        end
        else
        begin
            seq_reg   <= seq_next;
            ts_reg    <= ts_next;
            left_reg  <= left_next;
            fill_reg  <= fill_next;
            hdr_reg   <= hdr_next;
            frag_reg  <= frag_next;
            first_reg <= first_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PAYLOAD_TYPE: pt_reg          <= cfg_data[6:0];
                    REG_SSRC:         ssrc_reg        <= cfg_data;
                    REG_TS_STEP:      ts_step_reg     <= cfg_data;
                    REG_MAX_PAYLOAD:  max_payload_reg <= cfg_data[10:0];
                    default:          pt_reg          <= pt_reg;
                endcase
            end
        end
    end

endmodule

@@ src/rtpfu_emit.sv @@
// ----------------------------------------------------------------------------
// rtpfu_emit
// Expands queued commands into packet bytes, one byte per cycle, into an
// output register that the consumer pops; a byte left unpopped stalls it.
// ----------------------------------------------------------------------------
module rtpfu_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  rtpfu_pkg::cmd_t     cmd,
    input  logic                cmd_valid,
    input  rtpfu_pkg::hdr_cfg_t hdr_cfg,
    input  logic                pop,
    output logic                cmd_pop,
    output logic                empty,
    output logic [7:0]          packet_byte,
    output logic                packet_end,
    output logic                run_end
);
    import rtpfu_pkg::*;

    logic             out_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       byte_reg;
    logic             pend_reg;
    logic             run_end_reg;

    logic [IDX_W-1:0] last_idx;
    logic             at_last;
    logic             advance;
    logic             load;
    logic [7:0]       byte_sel;

    // position of the final byte of this command
    always_comb
    begin
        case (cmd.kind)
            CMD_SINGLE: last_idx = LAST_SINGLE;
            CMD_FRAG:   last_idx = LAST_FRAG;
            default:    last_idx = '0;
        endcase
    end

    assign at_last = (idx_reg == last_idx);
    assign advance = !out_valid_reg || pop;
    assign load    = advance && cmd_valid;
    assign cmd_pop = load && at_last;

    // header byte mux
    always_comb
    begin
        case (idx_reg)
            4'd0:       byte_sel = RTP_V2_BYTE;
            4'd1:       byte_sel = {cmd.marker, hdr_cfg.payload_type};
            4'd2:       byte_sel = cmd.seq[15:8];
            4'd3:       byte_sel = cmd.seq[7:0];
            4'd4:       byte_sel = cmd.ts[31:24];
            4'd5:       byte_sel = cmd.ts[23:16];
            4'd6:       byte_sel = cmd.ts[15:8];
            4'd7:       byte_sel = cmd.ts[7:0];
            4'd8:       byte_sel = hdr_cfg.ssrc[31:24];
            4'd9:       byte_sel = hdr_cfg.ssrc[23:16];
            4'd10:      byte_sel = hdr_cfg.ssrc[15:8];
            4'd11:      byte_sel = hdr_cfg.ssrc[7:0];
            IDX_FU_IND: byte_sel = cmd.fu_ind;
            IDX_FU_HDR: byte_sel = cmd.fu_hdr;
            default:    byte_sel = cmd.data;
        endcase
    end

    // output valid and byte position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= at_last ? '0 : idx_reg + 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= at_last ? cmd.data : byte_sel;
            pend_reg    <= at_last && cmd.pend;
            run_end_reg <= at_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign packet_byte = byte_reg;
    assign packet_end  = pend_reg;
    assign run_end     = run_end_reg;

endmodule

@@ src/rtp_h264_fua_packetizer.sv @@
// ----------------------------------------------------------------------------
// rtp_h264_fua_packetizer
// H.264 NAL unit to RTP packetizer with single-unit packets and FU-A
// fragmentation, byte-wide queue interfaces on both sides.
// ----------------------------------------------------------------------------
// results pass the command queue and output register; throughput: one NAL byte
//   per cycle while the queue is not full; a packet-opening byte occupies the
//   back end for 13 (single unit) or 15 (FU-A fragment) bytes, one byte per
//   cycle as popped; a four-entry command queue lets the front take bytes meanwhile
// reset: asynchronous, active low; clears unit state and restores register defaults
module rtp_h264_fua_packetizer #(
    parameter int unsigned MAX_UNIT_BYTES = rtpfu_pkg::MAX_UNIT_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  nal_byte,
    input  logic        starts_unit,
    input  logic [15:0] unit_length,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  packet_byte,
    output logic        packet_end,
    output logic        run_end,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import rtpfu_pkg::*;

    logic     accept;
    logic     cmd_push;
    cmd_t     cmd_in;
    cmd_t     cmd_out;
    logic     cmd_valid;
    logic     cmd_pop;
    hdr_cfg_t hdr_cfg;

    // request accepted
    assign accept = push && !full;

    // front end: classify bytes
    rtpfu_front #(
        .MAX_UNIT_BYTES (MAX_UNIT_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .nal_byte    (nal_byte),
        .starts_unit (starts_unit),
        .unit_length (unit_length),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .hdr_cfg     (hdr_cfg),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    // command queue
    rtpfu_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (cmd_in),
        .rd_en  (cmd_pop),
        .rd_cmd (cmd_out),
        .full   (full),
        .valid  (cmd_valid)
    );

    // back end: byte serializer
    rtpfu_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_out),
        .cmd_valid   (cmd_valid),
        .hdr_cfg     (hdr_cfg),
        .pop         (pop),
        .cmd_pop     (cmd_pop),
        .empty       (empty),
        .packet_byte (packet_byte),
        .packet_end  (packet_end),
        .run_end     (run_end)
    );

endmodule

@@ src/rtpfu_checker.sv @@
// ----------------------------------------------------------------------------
// rtpfu_checker
// Port-level checks on the packetizer result side, bound to the top level.
// ----------------------------------------------------------------------------
module rtpfu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] packet_byte,
    input logic       packet_end,
    input logic       run_end
);

    // nothing is offered while reset is held
    a_empty_in_reset: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result offered during reset");

    // a packet always closes on the last result of its request
    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && packet_end) |-> run_end)
        else $error("packet end inside a run");

    // the rest of a run follows without a gap
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !run_end) |=> !empty)
        else $error("run broken off");

    // a waiting result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(packet_byte)
                              && $stable(packet_end) && $stable(run_end)))
        else $error("waiting result changed");

endmodule

bind rtp_h264_fua_packetizer rtpfu_checker u_rtpfu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .packet_byte (packet_byte),
    .packet_end  (packet_end),
    .run_end     (run_end)
);

@@ verif/tb_rtp_h264_fua_packetizer.sv @@
// ----------------------------------------------------------------------------
// tb_rtp_h264_fua_packetizer
// Self-checking bench for the RTP H.264 packetizer. NAL bytes are pushed
// through the input queue with random gaps while a local packetizer model
// builds the expected RTP byte stream; every popped byte is compared with
// the oldest expected one. Covers single-unit packets, FU-A fragmentation,
// register extremes, truncated and abandoned units, stray bytes, a payload
// limit change in the middle of a unit and bursts of one-byte units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rtp_h264_fua_packetizer;

    import rtpfu_pkg::*;

    // generous bound: every request at fifteen bytes under the longest gaps
    localparam int unsigned CYCLE_LIMIT = 4000000;
    // quiet cycles after the last expected byte
    localparam int SETTLE_CYCLES = 16;

    // one expected output byte
    typedef struct {
        logic [7:0] data;
        logic       pend;
        logic       last;
    } rtp_byte_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  nal_byte;
    logic        starts_unit;
    logic [15:0] unit_length;
    logic        empty;
    logic        pop;
    logic [7:0]  packet_byte;
    logic        packet_end;
    logic        run_end;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // expected bytes, oldest first, and the bytes of the request being built
    rtp_byte_t   rtp_bytes_due[$];
    rtp_byte_t   run_bytes[$];

    int          err_count;
    int          pop_stall;
    int unsigned cycle_cnt;
    bit          no_idle;

    // model copy of the registers
    logic [6:0]  pt_reg;
    logic [31:0] ssrc_reg;
    logic [31:0] step_reg;
    logic [10:0] mp_reg;

    // model copy of the unit state
    logic [15:0] seq_num;
    logic [31:0] cur_ts;
    int unsigned bytes_left;
    int unsigned frag_fill;
    logic [7:0]  unit_hdr;
    bit          in_frag;
    bit          first_frag;

    rtp_h264_fua_packetizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .nal_byte    (nal_byte),
        .starts_unit (starts_unit),
        .unit_length (unit_length),
        .empty       (empty),
        .pop         (pop),
        .packet_byte (packet_byte),
        .packet_end  (packet_end),
        .run_end     (run_end),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // payload limit as the block uses it
    function automatic int unsigned payload_limit();
        if (mp_reg < PAYLOAD_MIN)
            return 32'(PAYLOAD_MIN);
        if (mp_reg > PAYLOAD_MAX)
            return 32'(PAYLOAD_MAX);
        return 32'(mp_reg);
    endfunction

    function automatic void stage_byte(input logic [7:0] b, input logic pend);
        rtp_byte_t rb;
        rb.data = b;
        rb.pend = pend;
        rb.last = 1'b0;
        run_bytes.push_back(rb);
    endfunction

    // 12-byte RTP header, consumes one sequence number
    function automatic void stage_header(input logic marker);
        stage_byte(RTP_V2_BYTE, 1'b0);
        stage_byte({marker, pt_reg}, 1'b0);
        stage_byte(seq_num[15:8], 1'b0);
        stage_byte(seq_num[7:0], 1'b0);
        stage_byte(cur_ts[31:24], 1'b0);
        stage_byte(cur_ts[23:16], 1'b0);
        stage_byte(cur_ts[15:8], 1'b0);
        stage_byte(cur_ts[7:0], 1'b0);
        stage_byte(ssrc_reg[31:24], 1'b0);
        stage_byte(ssrc_reg[23:16], 1'b0);
        stage_byte(ssrc_reg[15:8], 1'b0);
        stage_byte(ssrc_reg[7:0], 1'b0);
        seq_num = seq_num + 16'd1;
    endfunction

    // expected bytes for one accepted nal request
    task automatic packetize_request(input logic [7:0] b, input logic s,
                                     input logic [15:0] l);
        int unsigned lim;
        int unsigned len;
        bit          last;
        bit          pend;
        rtp_byte_t   rb;
        lim = payload_limit();
        run_bytes.delete();
        if (s)
        begin
            // zero length counts as one; 16 bits never exceed the unit cap
            len = (l == 16'd0) ? 32'd1 : 32'(l);
            cur_ts = cur_ts + step_reg;
            unit_hdr = b;
            frag_fill = 0;
            bytes_left = len - 1;
            if (len <= lim)
            begin
                in_frag = 1'b0;
                first_frag = 1'b0;
                stage_header(1'b1);
                stage_byte(b, bytes_left == 0);
            end
            else
            begin
                // header byte is held back for the fu indicator and fu header
                in_frag = 1'b1;
                first_frag = 1'b1;
            end
        end
        else if (bytes_left != 0)
        begin
            if (in_frag)
            begin
                // fragment opening: E and marker fixed here
                if (frag_fill == 0)
                begin
                    last = (bytes_left <= lim);
                    stage_header(last);
                    stage_byte({unit_hdr[7:5], FU_A_TYPE}, 1'b0);
                    stage_byte({first_frag, last, 1'b0, unit_hdr[4:0]}, 1'b0);
                    first_frag = 1'b0;
                end
                bytes_left--;
                frag_fill++;
                pend = (bytes_left == 0) || (frag_fill >= lim);
                stage_byte(b, pend);
                if (pend)
                    frag_fill = 0;
                if (bytes_left == 0)
                    in_frag = 1'b0;
            end
            else
            begin
                bytes_left--;
                stage_byte(b, bytes_left == 0);
            end
        end
        // stray bytes leave nothing staged
        while (run_bytes.size() != 0)
        begin
            rb = run_bytes.pop_front();
            rb.last = (run_bytes.size() == 0);
            rtp_bytes_due.push_back(rb);
        end
    endtask

    // send one nal request, leaving push high after acceptance
    task automatic push_nal_byte(input logic [7:0] b, input logic s, input logic [15:0] l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        nal_byte <= b;
        starts_unit <= s;
        unit_length <= l;
        do
            @(posedge clk);
        while (full);
        packetize_request(b, s, l);
    endtask

    // header byte then count-1 data bytes with junk in unit_length
    task automatic send_unit(input logic [7:0] hdr, input logic [15:0] len_field,
                             input int count);
        push_nal_byte(hdr, 1'b1, len_field);
        for (int i = 1; i < count; i++)
            push_nal_byte(8'($urandom), 1'b0, 16'($urandom));
    endtask

    // sender holds off until every expected byte has been popped
    task automatic wait_drain();
        push <= 1'b0;
        @(posedge clk);
        while (rtp_bytes_due.size() != 0)
            @(posedge clk);
    endtask

    // drained plus time for requests that produce no bytes
    task automatic wait_idle();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_PAYLOAD_TYPE: pt_reg = value[6:0];
            REG_SSRC:         ssrc_reg = value;
            REG_TS_STEP:      step_reg = value;
            REG_MAX_PAYLOAD:  mp_reg = value[10:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [31:0] pt, input logic [31:0] ssrc,
                                input logic [31:0] step, input logic [31:0] maxp);
        wait_idle();
        write_reg(REG_PAYLOAD_TYPE, pt);
        write_reg(REG_SSRC, ssrc);
        write_reg(REG_TS_STEP, step);
        write_reg(REG_MAX_PAYLOAD, maxp);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_len(input int max_len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(1, 20);
        if (r < 85)
            return $urandom_range(21, max_len / 2);
        return $urandom_range(max_len / 2, max_len);
    endfunction

    // mix of whole units, cut units, strays, zero lengths and drain pauses
    task automatic run_random_units(input int n_items, input int max_len);
        int sent;
        int kind;
        int len;
        int cnt;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                len = pick_len(max_len);
                send_unit(8'($urandom), 16'(len), len);
                sent += len;
            end
            else if (kind < 80)
            begin
                // cut short; the next start abandons it
                len = $urandom_range(0, 65535);
                cnt = $urandom_range(1, 30);
                send_unit(8'($urandom), 16'(len), cnt);
                sent += cnt;
            end
            else if (kind < 88)
            begin
                cnt = $urandom_range(1, 3);
                repeat (cnt) push_nal_byte(8'($urandom), 1'b0, 16'($urandom));
            end
            else if (kind < 94)
            begin
                send_unit(8'($urandom), 16'd0, $urandom_range(1, 3));
                sent += 1;
            end
            else
                wait_drain();
        end
    endtask

    // reset register values, stray byte, zero length, all-ones bytes
    task automatic test_defaults();
        push_nal_byte(8'h55, 1'b0, 16'h0000);
        push_nal_byte(8'h00, 1'b1, 16'd0);
        push_nal_byte(8'hFF, 1'b1, 16'd2);
        push_nal_byte(8'hFF, 1'b0, 16'hFFFF);
    endtask

    // registers at both ends, payload limit clamped from below and above
    task automatic test_register_extremes();
        program_regs(32'h0, 32'h0, 32'h0, 32'd2047);
        push_nal_byte(8'h00, 1'b1, 16'd1);
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5);
        // 17 data bytes: one full fragment, then a one-byte last fragment
        push_nal_byte(8'hFF, 1'b1, 16'd18);
        for (int i = 1; i < 18; i++)
            push_nal_byte((i % 2) ? 8'h00 : 8'hFF, 1'b0, 16'h0000);
    endtask

    // longest unit started, left open mid-fragment by a new unit
    task automatic test_abandoned_unit();
        push_nal_byte(8'h65, 1'b1, 16'hFFFF);
        push_nal_byte(8'hA5, 1'b0, 16'h0000);
        push_nal_byte(8'h5A, 1'b0, 16'hFFFF);
        push_nal_byte(8'h41, 1'b1, 16'd1);
    endtask

    // payload limit raised while a fragment is half filled
    task automatic test_limit_change_mid_unit();
        program_regs(32'd96, $urandom, 32'd3600, 32'd16);
        send_unit(8'($urandom), 16'd40, 11);
        wait_idle();
        write_reg(REG_MAX_PAYLOAD, 32'd24);
        cfg_we <= 1'b0;
        for (int i = 11; i < 40; i++)
            push_nal_byte(8'($urandom), 1'b0, 16'($urandom));
    endtask

    task automatic test_random_traffic();
        program_regs($urandom, $urandom, $urandom, 32'd16);
        run_random_units(50, 60);
        program_regs($urandom, $urandom, $urandom, $urandom_range(17, 48));
        run_random_units(50, 60);
        // stretch with no idling on either side
        program_regs($urandom, $urandom, $urandom, $urandom_range(16, 32));
        no_idle = 1'b1;
        run_random_units(40, 48);
        wait_drain();
        no_idle = 1'b0;
    endtask

    // burst of one-byte units with no idling on either side, then random units
    task automatic test_single_burst();
        program_regs($urandom, $urandom, $urandom, 32'd1460);
        no_idle = 1'b1;
        repeat (16) push_nal_byte(8'($urandom), 1'b1, 16'd1);
        wait_drain();
        no_idle = 1'b0;
        program_regs($urandom, $urandom, $urandom, $urandom_range(16, 40));
        run_random_units(30, 48);
    endtask

    // result checker and pop driver
    always @(posedge clk)
    begin
        rtp_byte_t rb;
        if (rst_n && pop && !empty)
        begin
            if (rtp_bytes_due.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("%0t: unexpected result byte %02h end %b run %b",
                             $realtime, packet_byte, packet_end, run_end);
            end
            else
            begin
                rb = rtp_bytes_due.pop_front();
                if (packet_byte !== rb.data || packet_end !== rb.pend || run_end !== rb.last)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: mismatch exp byte %02h end %b run %b, got %02h %b %b",
                                 $realtime, rb.data, rb.pend, rb.last,
                                 packet_byte, packet_end, run_end);
                end
            end
        end
        if (no_idle)
            pop <= 1'b1;
        else if (pop_stall > 0)
        begin
            pop <= 1'b0;
            pop_stall--;
        end
        else
        begin
            pop_stall = pick_gap();
            pop <= (pop_stall == 0);
        end
    end

    // watchdog
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        err_count = 0;
        pop_stall = 0;
        no_idle = 1'b0;
        pt_reg = PT_RESET;
        ssrc_reg = SSRC_RESET;
        step_reg = TS_STEP_RESET;
        mp_reg = MAX_PAYLOAD_RESET;
        seq_num = 16'd0;
        cur_ts = 32'd0;
        bytes_left = 0;
        frag_fill = 0;
        unit_hdr = 8'h00;
        in_frag = 1'b0;
        first_frag = 1'b0;
        rst_n <= 1'b0;
        push <= 1'b0;
        nal_byte <= 8'h00;
        starts_unit <= 1'b0;
        unit_length <= 16'h0000;
        pop <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_PAYLOAD_TYPE;
        cfg_data <= 32'h0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_register_extremes();
        test_abandoned_unit();
        test_limit_change_mid_unit();
        test_random_traffic();
        test_single_burst();

        wait_idle();
        if (rtp_bytes_due.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
src/rtpfu_pkg.sv
src/rtpfu_cmd_fifo.sv
src/rtpfu_front.sv
src/rtpfu_emit.sv
src/rtp_h264_fua_packetizer.sv
src/rtpfu_checker.sv
verif/tb_rtp_h264_fua_packetizer.sv
